[src/double_ended_queue_macros.svh]
// Assertion macros used by the double-ended queue datapath.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define DQ_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dq: same-cycle check failed");
`define DQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dq: next-cycle check failed");
`else
`define DQ_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define DQ_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

[src/dq_pkg.sv]
// Shared types and constants of the double-ended queue.
package dq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RESP = 1'b1
    } state_t;

    typedef struct packed {
        logic    take;
        logic    ok;
        logic    push;
        logic    front;
        status_t code;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } dp_status_t;

endpackage

[src/double_ended_queue.sv]
// Top level of the bounded double-ended queue.
//
//  Channel   Direction  Ports                                           Moves
//  s_        in         s_valid s_ready s_kind s_data_in                one operation item
//  m_        out        m_valid m_ready m_status m_data_out m_count_out m_is_empty  one result item
//
// An item is answered in the cycle after it is taken; with m_ready held high one item
// per cycle flows, since a new item is taken in the same cycle the waiting result leaves.
// Throughput is set by the single result register and the registered RAM read.
// Reset clears the pointer and count; the ring store is not cleared and needs no pass.
// While a result waits with m_ready low, s_ready stays low and the queue holds.
module double_ended_queue #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_kind,
    input  logic [DATA_WIDTH-1:0] s_data_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_status,
    output logic [DATA_WIDTH-1:0] m_data_out,
    output logic [CW-1:0]         m_count_out,
    output logic                  m_is_empty
);

    dq_pkg::cmd_t       cmd;
    dq_pkg::dp_status_t dp_status;

    dq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_kind    (s_kind),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    dq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_data_in   (s_data_in),
        .dp_status   (dp_status),
        .m_status    (m_status),
        .m_data_out  (m_data_out),
        .m_count_out (m_count_out),
        .m_is_empty  (m_is_empty)
    );

endmodule

[src/dq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dq_ram #(
    parameter int WIDTH = dq_pkg::DATA_WIDTH_DEF,
    parameter int DEPTH = dq_pkg::DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/dq_ctrl.sv]
// Controller state machine: handshakes, operation decode and refusal checks.
module dq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    output logic               m_valid,
    input  logic               m_ready,
    input  dq_pkg::dp_status_t dp_status,
    output dq_pkg::cmd_t       cmd
);

    dq_pkg::state_t state_reg;
    dq_pkg::state_t state_next;
    dq_pkg::kind_t  kind;
    logic           take;

    assign kind = dq_pkg::kind_t'(s_kind);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dq_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dq_pkg::S_IDLE: begin
                if (take) begin
                    state_next = dq_pkg::S_RESP;
                end
            end
            dq_pkg::S_RESP: begin
                if (m_ready && !take) begin
                    state_next = dq_pkg::S_IDLE;
                end
            end
            default: state_next = dq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = (state_reg == dq_pkg::S_IDLE) || m_ready;
        m_valid   = (state_reg == dq_pkg::S_RESP);
        take      = s_valid && s_ready;
        cmd.take  = take;
        cmd.push  = 1'b0;
        cmd.front = 1'b0;
        unique case (kind)
            dq_pkg::OP_PUSH_FRONT: begin
                cmd.push  = 1'b1;
                cmd.front = 1'b1;
            end
            dq_pkg::OP_PUSH_BACK: begin
                cmd.push  = 1'b1;
                cmd.front = 1'b0;
            end
            dq_pkg::OP_POP_FRONT: begin
                cmd.push  = 1'b0;
                cmd.front = 1'b1;
            end
            dq_pkg::OP_POP_BACK: begin
                cmd.push  = 1'b0;
                cmd.front = 1'b0;
            end
            default: begin
                cmd.push  = 1'b0;
                cmd.front = 1'b0;
            end
        endcase
        cmd.ok = cmd.push ? !dp_status.full : !dp_status.empty;
        if (cmd.ok) begin
            cmd.code = dq_pkg::ST_DONE;
        end else if (cmd.push) begin
            cmd.code = dq_pkg::ST_FULL;
        end else begin
            cmd.code = dq_pkg::ST_EMPTY;
        end
    end

endmodule

[src/dq_datapath.sv]
// Datapath: ring pointers, entry count, ring store and result registers.
`include "double_ended_queue_macros.svh"

module dq_datapath #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF,
    localparam int AW        = $clog2(DEPTH),
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dq_pkg::cmd_t          cmd,
    input  logic [DATA_WIDTH-1:0] s_data_in,
    output dq_pkg::dp_status_t    dp_status,
    output logic [1:0]            m_status,
    output logic [DATA_WIDTH-1:0] m_data_out,
    output logic [CW-1:0]         m_count_out,
    output logic                  m_is_empty
);

    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [AW-1:0]         head_reg, head_next;
    logic [CW-1:0]         count_reg, count_next;
    dq_pkg::status_t       status_reg;
    logic                  popped_reg;
    logic [AW-1:0]         head_dec, head_inc, tail, back;
    logic [AW:0]           sum, sum_m1;
    logic                  wr_en, rd_en;
    logic [AW-1:0]         waddr, raddr;
    logic [DATA_WIDTH-1:0] rdata;

    always_comb begin
        head_dec = (head_reg == '0) ? LAST_A : head_reg - AW'(1);
        head_inc = (head_reg == LAST_A) ? '0 : head_reg + AW'(1);
        sum      = {1'b0, head_reg} + (AW + 1)'(count_reg);
        sum_m1   = sum - (AW + 1)'(1);
        tail     = (sum >= DEPTH_W) ? AW'(sum - DEPTH_W) : AW'(sum);
        back     = (sum_m1 >= DEPTH_W) ? AW'(sum_m1 - DEPTH_W) : AW'(sum_m1);
    end

    assign dp_status.full  = (count_reg == DEPTH_C);
    assign dp_status.empty = (count_reg == '0);

    assign wr_en = cmd.take && cmd.ok && cmd.push;
    assign rd_en = cmd.take && cmd.ok && !cmd.push;
    assign waddr = cmd.front ? head_dec : tail;
    assign raddr = cmd.front ? head_reg : back;

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (wr_en) begin
            count_next = count_reg + CW'(1);
            if (cmd.front) begin
                head_next = head_dec;
            end
        end else if (rd_en) begin
            count_next = count_reg - CW'(1);
            if (cmd.front) begin
                head_next = head_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            status_reg <= cmd.code;
            popped_reg <= rd_en;
        end
    end

    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (s_data_in),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign m_status    = status_reg;
    assign m_data_out  = popped_reg ? rdata : '0;
    assign m_count_out = count_reg;
    assign m_is_empty  = (count_reg == '0);

    `DQ_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= DEPTH_C)
    `DQ_ASSERT_IMPL(a_pop_not_empty, aclk, aresetn, rd_en, count_reg != '0)
    `DQ_ASSERT_NEXT(a_push_count, aclk, aresetn, wr_en, count_reg == $past(count_reg) + CW'(1))
    `DQ_ASSERT_NEXT(a_refuse_head, aclk, aresetn, cmd.take && !cmd.ok, $stable(head_reg))
    `DQ_ASSERT_NEXT(a_refuse_count, aclk, aresetn, cmd.take && !cmd.ok, $stable(count_reg))

endmodule

[bench/tb.sv]
// Self-checking testbench of the double-ended queue: directed and random traffic against a ring mirror.
import dq_pkg::*;

typedef struct {
    status_t                     status;
    logic [DATA_WIDTH_DEF-1:0]   word;
    logic [$clog2(DEPTH_DEF+1)-1:0] fill;
    logic                        empty;
} dq_outcome_t;

class deque_mirror;
    logic [DATA_WIDTH_DEF-1:0] ring [DEPTH_DEF];
    int                        head;
    int                        fill;
    int                        errors;
    dq_outcome_t               pending [$];

    function new();
        head   = 0;
        fill   = 0;
        errors = 0;
    endfunction

    function void note_item(kind_t op, logic [DATA_WIDTH_DEF-1:0] data);
        dq_outcome_t res;
        res.status = ST_DONE;
        res.word   = '0;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
            if (fill >= DEPTH_DEF) begin
                res.status = ST_FULL;
            end else if (op == OP_PUSH_FRONT) begin
                head = (head + DEPTH_DEF - 1) % DEPTH_DEF;
                ring[head] = data;
                fill++;
            end else begin
                ring[(head + fill) % DEPTH_DEF] = data;
                fill++;
            end
        end else begin
            if (fill == 0) begin
                res.status = ST_EMPTY;
            end else if (op == OP_POP_FRONT) begin
                res.word = ring[head];
                head = (head + 1) % DEPTH_DEF;
                fill--;
            end else begin
                res.word = ring[(head + fill - 1) % DEPTH_DEF];
                fill--;
            end
        end
        res.fill  = fill[$clog2(DEPTH_DEF+1)-1:0];
        res.empty = (fill == 0);
        pending.push_back(res);
    endfunction

    function void check_result(logic [1:0] status, logic [DATA_WIDTH_DEF-1:0] word,
                               logic [$clog2(DEPTH_DEF+1)-1:0] cnt, logic empty);
        dq_outcome_t want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result status %0d data %h count %0d empty %0d",
                     $time, status, word, cnt, empty);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            errors++;
        end
        if (word !== want.word) begin
            $display("%0t: data_out expected %h actual %h", $time, want.word, word);
            errors++;
        end
        if (cnt !== want.fill) begin
            $display("%0t: count_out expected %0d actual %0d", $time, want.fill, cnt);
            errors++;
        end
        if (empty !== want.empty) begin
            $display("%0t: is_empty expected %0d actual %0d", $time, want.empty, empty);
            errors++;
        end
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = DATA_WIDTH_DEF;
    localparam int CW = $clog2(DEPTH_DEF + 1);

    logic          aclk = 1'b0;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    logic [1:0]    s_kind;
    logic [DW-1:0] s_data_in;
    logic          m_valid;
    logic          m_ready;
    logic [1:0]    m_status;
    logic [DW-1:0] m_data_out;
    logic [CW-1:0] m_count_out;
    logic          m_is_empty;

    deque_mirror mirror = new();
    bit          send_burst;
    bit          recv_burst;

    double_ended_queue u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_data_in   (s_data_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_data_out  (m_data_out),
        .m_count_out (m_count_out),
        .m_is_empty  (m_is_empty)
    );

    always #5 aclk = ~aclk;

    task automatic send_op(kind_t op, logic [DW-1:0] data);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_kind    <= op;
        s_data_in <= data;
        do @(posedge aclk); while (!s_ready);
        mirror.note_item(op, data);
    endtask

    function automatic logic [DW-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: pick_word = '0;
            1: pick_word = '1;
            default: pick_word = $urandom;
        endcase
    endfunction

    initial begin
        int push_pct;
        kind_t op;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_kind    <= OP_PUSH_FRONT;
        s_data_in <= '0;
        m_ready   <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // empty pops, extreme words, fill to full, refused pushes, pops from both ends
        send_op(OP_POP_FRONT, 32'h1234_5678);
        send_op(OP_POP_BACK, '1);
        send_op(OP_PUSH_FRONT, '0);
        send_op(OP_PUSH_BACK, '1);
        for (int i = 0; i < DEPTH_DEF - 2; i++)
            send_op((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom);
        send_op(OP_PUSH_FRONT, 32'hA5A5_A5A5);
        send_op(OP_PUSH_BACK, 32'h5A5A_5A5A);
        send_op(OP_POP_FRONT, '0);
        send_op(OP_POP_BACK, '0);

        push_pct = 50;
        for (int i = 0; i < 750; i++) begin
            if (i % 32 == 0) begin
                case ($urandom_range(0, 3))
                    0: push_pct = 15;
                    1: push_pct = 85;
                    2: push_pct = 100;
                    default: push_pct = 50;
                endcase
                send_burst = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(1, 100) <= push_pct)
                op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            else
                op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
            send_op(op, pick_word());
        end
        s_valid <= 1'b0;

        while (mirror.pending.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mirror.errors == 0 && mirror.pending.size() == 0) begin
            $display("PASS double_ended_queue");
        end else begin
            $display("FAIL double_ended_queue");
        end
        $finish;
    end

    initial begin
        int stall;
        int taken;
        taken = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (taken % 40 == 0)
                recv_burst = ($urandom_range(0, 3) == 0);
            stall = recv_burst ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            mirror.check_result(m_status, m_data_out, m_count_out, m_is_empty);
            taken++;
        end
    end

    initial begin
        #2ms;
        $display("FAIL double_ended_queue");
        $finish;
    end
endmodule

[filelist.f]
+incdir+src
src/dq_pkg.sv
src/dq_ram.sv
src/dq_ctrl.sv
src/dq_datapath.sv
src/double_ended_queue.sv
bench/tb.sv
